>>> sv/one_wire_temperature_reader_defines.svh
// Assertion helpers used by the RTL file of the one-wire temperature reader.
`ifndef ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH
`define ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define OWTR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define OWTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/owtr_pkg.sv
package owtr_pkg;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_R1_LOW  = 5'd1,
        PH_R1_REL  = 5'd2,
        PH_R1_TAIL = 5'd3,
        PH_W_SKIP1 = 5'd4,
        PH_W_CONV  = 5'd5,
        PH_POLL    = 5'd6,
        PH_R2_LOW  = 5'd7,
        PH_R2_REL  = 5'd8,
        PH_R2_TAIL = 5'd9,
        PH_W_SKIP2 = 5'd10,
        PH_W_RPAD  = 5'd11,
        PH_RD0     = 5'd12,
        PH_RD1     = 5'd13,
        PH_R3_LOW  = 5'd14,
        PH_R3_REL  = 5'd15,
        PH_R3_TAIL = 5'd16
    } phase_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_RESET_LOW   = 3'd0;
    localparam cfg_idx_t CFG_PRES_SAMPLE = 3'd1;
    localparam cfg_idx_t CFG_RESET_TAIL  = 3'd2;
    localparam cfg_idx_t CFG_SLOT        = 3'd3;
    localparam cfg_idx_t CFG_READ_SAMPLE = 3'd4;
    localparam cfg_idx_t CFG_SKIP_ROM    = 3'd5;
    localparam cfg_idx_t CFG_CONVERT     = 3'd6;
    localparam cfg_idx_t CFG_READ_PAD    = 3'd7;

endpackage

>>> sv/one_wire_temperature_reader.sv
// Channel | Direction | Contents (lowest bit first)
// s_      | in        | s_tdata: action, line_in, zero fill to 8 bits
// m_      | out       | m_tdata: drive_low, busy_res, done_res, no_presence,
//         |           |          temperature_raw[15:0], zero fill to 24 bits
// cfg_    | in        | cfg_index: register number, cfg_data: register value
//
// Each input transfer is one microsecond tick and yields one result transfer
// in the next cycle; a new tick can be taken every cycle while m_tready is high.
// The sequencer state and the timing counter advance once per accepted tick.
// Reset (aresetn low at a clock edge) returns the sequencer to idle and loads
// the default timing and command registers. A stalled result holds its data
// and blocks further ticks until it is taken.
`include "one_wire_temperature_reader_defines.svh"

module one_wire_temperature_reader (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [owtr_pkg::S_DATA_W-1:0]      s_tdata,   // action, line_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // drive_low, busy_res, done_res, no_presence, temperature_raw
    output logic [owtr_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import owtr_pkg::*;

    logic [9:0]  reset_low_reg, pres_sample_reg, reset_tail_reg;
    logic [7:0]  slot_reg;
    logic [3:0]  read_sample_reg;
    logic [7:0]  skip_rom_reg, convert_reg, read_pad_reg;

    phase_t      phase_reg, phase_next;
    logic [9:0]  tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic [15:0] temp_reg, temp_next;
    logic        presence_reg, presence_next;

    logic        m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic        s_accept;
    logic        action, line_in;
    logic        starting;
    phase_t      cur_phase;
    logic [9:0]  cur_tick;
    logic [2:0]  cur_bit;
    logic [10:0] tick_plus, dur;
    logic        part_end;
    logic [4:0]  sample_tick;
    logic [7:0]  read_span;
    logic        sample_now;
    logic [7:0]  shift_sampled;
    logic        drive_low, busy_res, done_res;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign action    = s_tdata[0];
    assign line_in   = s_tdata[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg   <= 10'd480;
            pres_sample_reg <= 10'd60;
            reset_tail_reg  <= 10'd420;
            slot_reg        <= 8'd60;
            read_sample_reg <= 4'd14;
            skip_rom_reg    <= 8'd204;
            convert_reg     <= 8'd68;
            read_pad_reg    <= 8'd190;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_RESET_LOW:   reset_low_reg   <= cfg_data;
                CFG_PRES_SAMPLE: pres_sample_reg <= cfg_data;
                CFG_RESET_TAIL:  reset_tail_reg  <= cfg_data;
                CFG_SLOT:        slot_reg        <= cfg_data[7:0];
                CFG_READ_SAMPLE: read_sample_reg <= cfg_data[3:0];
                CFG_SKIP_ROM:    skip_rom_reg    <= cfg_data[7:0];
                CFG_CONVERT:     convert_reg     <= cfg_data[7:0];
                CFG_READ_PAD:    read_pad_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign starting  = (phase_reg == PH_IDLE) && action;
    assign cur_tick  = starting ? 10'd0 : tick_reg;
    assign cur_bit   = starting ? 3'd0 : bit_reg;
    assign tick_plus = {1'b0, cur_tick} + 11'd1;

    always_comb begin
        cur_phase = PH_IDLE;
        unique case (phase_reg)
            PH_IDLE: cur_phase = action ? PH_R1_LOW : PH_IDLE;
            PH_R1_LOW, PH_R1_REL, PH_R1_TAIL, PH_W_SKIP1, PH_W_CONV, PH_POLL,
            PH_R2_LOW, PH_R2_REL, PH_R2_TAIL, PH_W_SKIP2, PH_W_RPAD, PH_RD0,
            PH_RD1, PH_R3_LOW, PH_R3_REL, PH_R3_TAIL: cur_phase = phase_reg;
            default: cur_phase = PH_IDLE;
        endcase
    end

    assign sample_tick = {1'b0, read_sample_reg} + 5'd1;
    assign read_span   = (slot_reg < {3'b0, sample_tick}) ? {3'b0, sample_tick} : slot_reg;
    assign sample_now  = (cur_tick == {5'b0, sample_tick});
    assign shift_sampled = sample_now ? {line_in, shift_reg[7:1]} : shift_reg;

    // Length of the current part of the sequence; a zero register counts as one tick.
    always_comb begin
        dur = 11'd1;
        unique case (cur_phase) inside
            PH_R1_LOW, PH_R2_LOW, PH_R3_LOW:
                dur = (reset_low_reg == 10'd0) ? 11'd1 : {1'b0, reset_low_reg};
            PH_R1_REL, PH_R2_REL, PH_R3_REL:
                dur = {1'b0, pres_sample_reg} + 11'd1;
            PH_R1_TAIL, PH_R2_TAIL, PH_R3_TAIL:
                dur = (reset_tail_reg == 10'd0) ? 11'd1 : {1'b0, reset_tail_reg};
            PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_RPAD:
                dur = {3'b0, slot_reg} + 11'd1;
            PH_POLL, PH_RD0, PH_RD1:
                dur = {3'b0, read_span} + 11'd1;
            default: dur = 11'd1;
        endcase
    end

    assign part_end = (tick_plus >= dur);

    // Next state of the sequencer and its datapath.
    always_comb begin
        phase_next    = cur_phase;
        tick_next     = part_end ? 10'd0 : tick_plus[9:0];
        bit_next      = cur_bit;
        shift_next    = shift_reg;
        low_byte_next = low_byte_reg;
        temp_next     = temp_reg;
        presence_next = presence_reg;
        unique case (cur_phase) inside
            PH_IDLE: begin
                tick_next = tick_reg;
                bit_next  = bit_reg;
            end
            PH_R1_LOW, PH_R2_LOW, PH_R3_LOW,
            PH_R1_TAIL, PH_R2_TAIL: begin
                if (part_end) begin
                    phase_next = phase_t'(cur_phase + 5'd1);
                end
            end
            PH_R3_TAIL: begin
                if (part_end) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_R1_REL, PH_R2_REL, PH_R3_REL: begin
                if (part_end) begin
                    presence_next = line_in;
                    phase_next    = phase_t'(cur_phase + 5'd1);
                end
            end
            PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_RPAD: begin
                if (part_end) begin
                    shift_next = {1'b0, shift_reg[7:1]};
                    if (cur_bit == 3'd7) begin
                        phase_next = phase_t'(cur_phase + 5'd1);
                    end else begin
                        bit_next = cur_bit + 3'd1;
                    end
                end
            end
            PH_POLL: begin
                shift_next = shift_sampled;
                if (part_end && shift_sampled[7]) begin
                    phase_next = PH_R2_LOW;
                end
            end
            PH_RD0, PH_RD1: begin
                shift_next = shift_sampled;
                if (part_end) begin
                    if (cur_bit == 3'd7) begin
                        if (cur_phase == PH_RD0) begin
                            low_byte_next = shift_sampled;
                        end else begin
                            temp_next = {shift_sampled, low_byte_reg};
                        end
                        phase_next = phase_t'(cur_phase + 5'd1);
                    end else begin
                        bit_next = cur_bit + 3'd1;
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase
        if (phase_next != cur_phase) begin
            tick_next = 10'd0;
            bit_next  = 3'd0;
            if (phase_next == PH_W_SKIP1 || phase_next == PH_W_SKIP2) begin
                shift_next = skip_rom_reg;
            end else if (phase_next == PH_W_CONV) begin
                shift_next = convert_reg;
            end else if (phase_next == PH_W_RPAD) begin
                shift_next = read_pad_reg;
            end
        end
    end

    // Line drive and status flags for the current tick.
    always_comb begin
        drive_low = 1'b0;
        busy_res  = (cur_phase != PH_IDLE);
        done_res  = (cur_phase == PH_R3_TAIL) && part_end;
        unique case (cur_phase) inside
            PH_R1_LOW, PH_R2_LOW, PH_R3_LOW:
                drive_low = 1'b1;
            PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_RPAD:
                drive_low = (cur_tick == 10'd0) ? 1'b1 : !shift_reg[0];
            PH_POLL, PH_RD0, PH_RD1:
                drive_low = (cur_tick == 10'd0);
            default: drive_low = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= 10'd0;
            bit_reg      <= 3'd0;
            shift_reg    <= 8'd0;
            low_byte_reg <= 8'd0;
            temp_reg     <= 16'd0;
            presence_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg    <= phase_next;
                tick_reg     <= tick_next;
                bit_reg      <= bit_next;
                shift_reg    <= shift_next;
                low_byte_reg <= low_byte_next;
                temp_reg     <= temp_next;
                presence_reg <= presence_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {4'b0, temp_next, presence_next, done_res, busy_res, drive_low};
        end
    end

    `OWTR_ASSERT_NEXT(a_result_follows, s_accept, m_tvalid, "accepted tick gave no result")
    `OWTR_ASSERT_SAME(a_idle_counters, phase_reg == PH_IDLE,
        tick_reg == 10'd0 && bit_reg == 3'd0, "idle sequencer holds stale counters")
    `OWTR_ASSERT_NEXT(a_done_to_idle, s_accept && done_res,
        phase_reg == PH_IDLE && m_tdata[2] && m_tdata[1], "completion did not return to idle")
    `OWTR_ASSERT_SAME(a_done_busy, m_tvalid && m_tdata[2], m_tdata[1],
        "completion flagged outside a running sequence")

endmodule

>>> dv/tb_one_wire_temperature_reader.sv
`timescale 1ns / 100ps

module tb_one_wire_temperature_reader;

    import owtr_pkg::*;

    typedef struct packed {
        logic signed [15:0] temp_raw;
        logic               no_presence;
        logic               done;
        logic               busy;
        logic               drive_low;
    } bus_tick_t;

    typedef struct packed {
        logic      typed;
        bus_tick_t want;
    } tick_tag_t;

    typedef struct packed {
        logic      act;
        logic      level;
        logic      typed;
        bus_tick_t want;
    } tick_row_t;

    typedef enum int {
        TIMING_ZERO,
        TIMING_MIN,
        TIMING_SHORT_READ,
        TIMING_WIDEST,
        TIMING_RANDOM
    } timing_kind_t;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_TICKS = 145;
    localparam int NUM_PHASES  = 8;

    localparam bus_tick_t LINE_IDLE   = '0;
    localparam bus_tick_t RESET_PULSE = '{temp_raw: 16'sd0, no_presence: 1'b0, done: 1'b0,
                                          busy: 1'b1, drive_low: 1'b1};

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;    // action, line_in, zero fill
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;    // drive_low, busy_res, done_res, no_presence,
                                       // temperature_raw, zero fill
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    one_wire_temperature_reader i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Timing and command copies held by the sequencer model.
    int         t_reset_low;
    int         t_pres_sample;
    int         t_reset_tail;
    int         t_slot;
    int         t_read_sample;
    logic [7:0] cmd_skip;
    logic [7:0] cmd_convert;
    logic [7:0] cmd_read_pad;

    phase_t      seq_phase;
    int          slot_tick;
    int          bit_pos;
    logic [7:0]  shift_reg;
    logic [7:0]  low_byte_q;
    logic [15:0] temp_latched;
    logic        presence_seen;

    bus_tick_t pending_bus_ticks[$];
    tick_tag_t tick_tags[$];

    int src_idle_pct;
    int sink_stall_pct;
    int mismatches;
    int ticks_taken;
    int reads_done;
    int quiet_cycles;

    int idle_src[4]   = '{0, 51, 0, 33};
    int stall_sink[4] = '{0, 0, 51, 33};

    timing_kind_t phase_timing[NUM_PHASES] = '{TIMING_WIDEST, TIMING_ZERO, TIMING_MIN,
                                               TIMING_RANDOM, TIMING_SHORT_READ,
                                               TIMING_RANDOM, TIMING_ZERO, TIMING_RANDOM};

    // Rows run with the timing loaded at reset.
    tick_row_t directed_rows[12] = '{
        '{act: 1'b0, level: 1'b0, typed: 1'b1, want: LINE_IDLE},
        '{act: 1'b0, level: 1'b1, typed: 1'b1, want: LINE_IDLE},
        '{act: 1'b1, level: 1'b0, typed: 1'b1, want: RESET_PULSE},
        '{act: 1'b1, level: 1'b1, typed: 1'b1, want: RESET_PULSE},
        '{act: 1'b0, level: 1'b0, typed: 1'b1, want: RESET_PULSE},
        '{act: 1'b1, level: 1'b0, typed: 1'b0, want: LINE_IDLE},
        '{act: 1'b0, level: 1'b1, typed: 1'b0, want: LINE_IDLE},
        '{act: 1'b1, level: 1'b1, typed: 1'b0, want: LINE_IDLE},
        '{act: 1'b0, level: 1'b0, typed: 1'b0, want: LINE_IDLE},
        '{act: 1'b0, level: 1'b1, typed: 1'b0, want: LINE_IDLE},
        '{act: 1'b1, level: 1'b0, typed: 1'b0, want: LINE_IDLE},
        '{act: 1'b0, level: 1'b1, typed: 1'b0, want: LINE_IDLE}
    };

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void reset_sequencer_model();
        t_reset_low   = 480;
        t_pres_sample = 60;
        t_reset_tail  = 420;
        t_slot        = 60;
        t_read_sample = 14;
        cmd_skip      = 8'd204;
        cmd_convert   = 8'd68;
        cmd_read_pad  = 8'd190;
        seq_phase     = PH_IDLE;
        slot_tick     = 0;
        bit_pos       = 0;
        shift_reg     = '0;
        low_byte_q    = '0;
        temp_latched  = '0;
        presence_seen = 1'b0;
    endfunction

    function automatic void enter_phase(phase_t p);
        seq_phase = p;
        slot_tick = 0;
        bit_pos   = 0;
        case (p)
            PH_W_SKIP1, PH_W_SKIP2: shift_reg = cmd_skip;
            PH_W_CONV:              shift_reg = cmd_convert;
            PH_W_RPAD:              shift_reg = cmd_read_pad;
            default:                ;
        endcase
    endfunction

    // Steps the slot timer; returns 1 on the last tick of a part lasting dur ticks.
    function automatic bit span_done(int dur);
        int d;
        d = (dur == 0) ? 1 : dur;
        if (slot_tick + 1 >= d) begin
            slot_tick = 0;
            return 1'b1;
        end
        slot_tick = (slot_tick + 1) & 1023;
        return 1'b0;
    endfunction

    function automatic bus_tick_t advance_sequencer(logic start, logic level);
        bus_tick_t r;
        int        span;
        r = '0;
        if (seq_phase == PH_IDLE && start) begin
            enter_phase(PH_R1_LOW);
        end
        if (seq_phase != PH_IDLE) begin
            r.busy = 1'b1;
            case (seq_phase)
                PH_R1_LOW, PH_R2_LOW, PH_R3_LOW: begin
                    r.drive_low = 1'b1;
                    if (span_done(t_reset_low)) begin
                        enter_phase(phase_t'(seq_phase + 5'd1));
                    end
                end
                PH_R1_REL, PH_R2_REL, PH_R3_REL: begin
                    if (span_done(t_pres_sample + 1)) begin
                        presence_seen = level;
                        enter_phase(phase_t'(seq_phase + 5'd1));
                    end
                end
                PH_R1_TAIL, PH_R2_TAIL, PH_R3_TAIL: begin
                    if (span_done(t_reset_tail)) begin
                        if (seq_phase == PH_R3_TAIL) begin
                            enter_phase(PH_IDLE);
                            r.done = 1'b1;
                        end else begin
                            enter_phase(phase_t'(seq_phase + 5'd1));
                        end
                    end
                end
                PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_RPAD: begin
                    r.drive_low = (slot_tick == 0) ? 1'b1 : ~shift_reg[0];
                    if (span_done(t_slot + 1)) begin
                        shift_reg = shift_reg >> 1;
                        if (bit_pos == 7) begin
                            enter_phase(phase_t'(seq_phase + 5'd1));
                        end else begin
                            bit_pos = bit_pos + 1;
                        end
                    end
                end
                default: begin
                    span = (t_slot < t_read_sample + 1) ? t_read_sample + 1 : t_slot;
                    r.drive_low = (slot_tick == 0);
                    if (slot_tick == t_read_sample + 1) begin
                        shift_reg = {level, shift_reg[7:1]};
                    end
                    if (span_done(span + 1)) begin
                        if (seq_phase == PH_POLL) begin
                            if (shift_reg[7]) begin
                                enter_phase(PH_R2_LOW);
                            end
                        end else if (bit_pos == 7) begin
                            if (seq_phase == PH_RD0) begin
                                low_byte_q = shift_reg;
                            end else begin
                                temp_latched = {shift_reg, low_byte_q};
                            end
                            enter_phase(phase_t'(seq_phase + 5'd1));
                        end else begin
                            bit_pos = bit_pos + 1;
                        end
                    end
                end
            endcase
        end
        r.no_presence = presence_seen;
        r.temp_raw    = temp_latched;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        bus_tick_t got;
        bus_tick_t want;
        bus_tick_t predicted;
        tick_tag_t tag;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RESET_LOW:   t_reset_low   = int'(cfg_data);
                    CFG_PRES_SAMPLE: t_pres_sample = int'(cfg_data);
                    CFG_RESET_TAIL:  t_reset_tail  = int'(cfg_data);
                    CFG_SLOT:        t_slot        = int'(cfg_data[7:0]);
                    CFG_READ_SAMPLE: t_read_sample = int'(cfg_data[3:0]);
                    CFG_SKIP_ROM:    cmd_skip      = cfg_data[7:0];
                    CFG_CONVERT:     cmd_convert   = cfg_data[7:0];
                    CFG_READ_PAD:    cmd_read_pad  = cfg_data[7:0];
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                tag = tick_tags.pop_front();
                predicted = advance_sequencer(s_tdata[0], s_tdata[1]);
                pending_bus_ticks.push_back(tag.typed ? tag.want : predicted);
                ticks_taken++;
            end
            if (m_tvalid && m_tready) begin
                got = bus_tick_t'(m_tdata[19:0]);
                if (pending_bus_ticks.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_bus_ticks.pop_front();
                    check_field("drive_low", want.drive_low, got.drive_low);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("done_res", want.done, got.done);
                    check_field("no_presence", want.no_presence, got.no_presence);
                    check_field("temperature_raw", want.temp_raw, got.temp_raw);
                    if (got.done) begin
                        reads_done++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("[one_wire_temperature_reader] ERROR");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic send_tick(logic act, logic level, logic typed, bus_tick_t want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-2){1'b0}}, level, act};
        tick_tags.push_back('{typed: typed, want: want});
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_bus_ticks.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
    endtask

    task automatic program_timing(timing_kind_t kind);
        int         rl;
        int         ps;
        int         rt;
        int         sl;
        int         rs;
        logic [7:0] c_skip;
        logic [7:0] c_conv;
        logic [7:0] c_pad;
        c_skip = 8'($urandom);
        c_conv = 8'($urandom);
        c_pad  = 8'($urandom);
        case (kind)
            TIMING_ZERO: begin
                rl = 0; ps = 0; rt = 0; sl = 0; rs = 0;
            end
            TIMING_MIN: begin
                rl = 1; ps = 1; rt = 1; sl = 16; rs = 1;
            end
            TIMING_SHORT_READ: begin
                rl = 2; ps = 3; rt = 2; sl = 5; rs = 14;
            end
            TIMING_WIDEST: begin
                rl = 1023; ps = 1023; rt = 1023; sl = 255; rs = 15;
                c_skip = 8'hFF;
                c_conv = 8'h00;
                c_pad  = 8'hFF;
            end
            default: begin
                rl = $urandom_range(0, 12);
                ps = $urandom_range(0, 12);
                rt = $urandom_range(0, 12);
                sl = $urandom_range(0, 24);
                rs = $urandom_range(0, 15);
            end
        endcase
        write_reg(CFG_RESET_LOW, rl);
        write_reg(CFG_PRES_SAMPLE, ps);
        write_reg(CFG_RESET_TAIL, rt);
        write_reg(CFG_SLOT, sl);
        write_reg(CFG_READ_SAMPLE, rs);
        write_reg(CFG_SKIP_ROM, c_skip);
        write_reg(CFG_CONVERT, c_conv);
        write_reg(CFG_READ_PAD, c_pad);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int n;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        mismatches     = 0;
        ticks_taken    = 0;
        reads_done     = 0;
        quiet_cycles   = 0;
        reset_sequencer_model();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_tick(directed_rows[i].act, directed_rows[i].level,
                      directed_rows[i].typed, directed_rows[i].want);
        end
        drain_results();
        program_timing(TIMING_ZERO);
        // With the line held high nobody answers presence and the whole word reads as ones.
        while (seq_phase != PH_IDLE) begin
            send_tick(1'b0, 1'b1, 1'b0, LINE_IDLE);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            program_timing(phase_timing[p]);
            src_idle_pct   = idle_src[p % 4];
            sink_stall_pct = stall_sink[p % 4];
            n = 0;
            while (n < PHASE_TICKS) begin
                if (n == 50 || $urandom_range(0, 299) == 0) begin
                    drain_results();
                end
                send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), 1'b0,
                          LINE_IDLE);
                n++;
            end
        end

        drain_results();
        repeat (4) @(posedge aclk);
        $display("Run covered %0d ticks: reset timing plus %0d register settings under four",
                 ticks_taken, NUM_PHASES);
        $display("idle and stall mixes, with %0d complete temperature reads.", reads_done);
        if (mismatches == 0) begin
            $display("[one_wire_temperature_reader] OK");
        end else begin
            $display("[one_wire_temperature_reader] ERROR");
        end
        $finish;
    end

endmodule
